@@ hw/rtl/cvkt_pkg.sv @@
`default_nettype none
package cvkt_pkg;

	// Fixed-point format and sizes.
	localparam int DATA_W  = 32;
	localparam int FRAC    = 16;
	localparam int COORDS  = 4;
	localparam int NSTATE  = 2 * COORDS;
	localparam int SUM_W   = DATA_W + 4;
	localparam int DIV_W   = DATA_W + FRAC;
	localparam int CNT_W   = $clog2(DIV_W + 1);
	localparam int CRD_W   = $clog2(COORDS);
	localparam int ELEM_W  = $clog2(NSTATE);
	localparam int CFG_W   = 31;
	localparam int IN_W    = 168;
	localparam int OUT_W   = 40;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [DATA_W-1:0]        umag_t;
	typedef logic [CRD_W-1:0]         coord_t;
	typedef logic [ELEM_W-1:0]        elem_t;

	localparam sum_t  SUM_MAX = sum_t'(64'sh7FFF_FFFF);
	localparam sum_t  SUM_MIN = -SUM_MAX - sum_t'(1);
	localparam sum_t  ONE     = sum_t'(64'sh1_0000);
	localparam logic [CFG_W-1:0] NOISE_RESET = CFG_W'(65536);

	// Operation codes of an input item.
	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_PREDICT = 2'd1,
		OP_UPDATE  = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	// Configuration register indexes.
	localparam logic REG_Q = 1'b0;
	localparam logic REG_R = 1'b1;

	// Multiply steps of an update.
	localparam logic [2:0] MUL_KP_Y  = 3'd0;
	localparam logic [2:0] MUL_KV_Y  = 3'd1;
	localparam logic [2:0] MUL_M_PP  = 3'd2;
	localparam logic [2:0] MUL_M_PV  = 3'd3;
	localparam logic [2:0] MUL_KV_PP = 3'd4;
	localparam logic [2:0] MUL_KV_PV = 3'd5;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		UOP_NONE,
		UOP_PRED,
		UOP_PREP,
		UOP_DIV_START,
		UOP_DIV_STORE,
		UOP_MUL,
		UOP_MUL_FIN,
		UOP_COMMIT,
		UOP_EMIT
	} uop_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRED,
		ST_PREP,
		ST_DIVS,
		ST_DIVW,
		ST_MUL,
		ST_MULF,
		ST_COMMIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       capture;
		uop_t       uop;
		logic [2:0] sel;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_busy;
	} stat_t;

	// Saturate a wide sum to the data range.
	function automatic data_t sat_sum(sum_t v);
		sum_t r;
		r = (v > SUM_MAX) ? SUM_MAX : ((v < SUM_MIN) ? SUM_MIN : v);
		return data_t'(r[DATA_W-1:0]);
	endfunction

	// Magnitude of a signed value; the most negative value maps to 2^(DATA_W-1).
	function automatic umag_t mag(data_t v);
		data_t n;
		n = -v;
		return v[DATA_W-1] ? umag_t'(n) : umag_t'(v);
	endfunction

	// Signed result from a magnitude, saturated.
	function automatic data_t from_mag(logic neg, logic [DIV_W-1:0] m);
		logic [DIV_W-1:0] lim;
		logic [DIV_W-1:0] c;
		logic [DIV_W-1:0] r;
		lim = neg ? (DIV_W'(1) << (DATA_W - 1)) : ((DIV_W'(1) << (DATA_W - 1)) - DIV_W'(1));
		c = (m > lim) ? lim : m;
		r = neg ? (~c + DIV_W'(1)) : c;
		return data_t'(r[DATA_W-1:0]);
	endfunction

	// Element index to coordinate and position/velocity select.
	function automatic coord_t elem_coord(elem_t e);
		return {e[2], e[0]};
	endfunction

	function automatic logic elem_is_vel(elem_t e);
		return e[1];
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/constant_velocity_kalman_tracker.sv @@
// Constant-velocity tracker for four coordinates, signed Q16.16 with saturation.
// Input channel s_*: one transfer carries an operation in s_tuser (init, predict,
// update) and its operands in s_tdata. Init writes one state element and gives no
// result. Predict and update each give eight results on m_*, one per state element
// in ascending index order, with m_tlast on the eighth.
// Configuration: cfg_we writes cfg_data to process noise (index 0) or measurement
// noise (index 1); write only while the block is idle.
// Sequence: predict works through the coordinates one at a time, then gives its
// results. Update works through the coordinates one at a time, each with the shared
// 48-step restoring divider run twice and six passes through the shared 32x32
// multiplier, then gives its results. Items are handled one at
// a time; s_tready is high only while no item is at work, and the last result may
// still wait in the output register while the next item is taken.
// Reset clears every estimate and covariance entry to zero and returns both noise
// registers to 1.0. A stalled receiver holds m_tvalid and m_tdata and pauses the block.
`default_nettype none
module constant_velocity_kalman_tracker import cvkt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// [2:0] state_index, [34:3] state_value, [66:35] meas_0, [98:67] meas_1,
	// [130:99] meas_2, [162:131] meas_3, rest zero
	input  wire logic [IN_W-1:0]  s_tdata,
	// [1:0] opcode
	input  wire logic [1:0]       s_tuser,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// [2:0] out_index, [34:3] out_value, rest zero
	output logic [OUT_W-1:0]      m_tdata,
	output logic                  m_tlast,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	cmd_t    cmd;
	stat_t   stat;
	opcode_t opcode;
	data_t   meas [COORDS];
	elem_t   out_index;
	data_t   out_value;

	assign opcode = opcode_t'(s_tuser);
	always_comb begin
		for (int c = 0; c < COORDS; c++)
			meas[c] = data_t'(s_tdata[35 + 32*c +: 32]);
	end

	cvkt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (opcode),
		.stat     (stat),
		.cmd      (cmd)
	);

	cvkt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (opcode),
		.state_index (s_tdata[2:0]),
		.state_value (data_t'(s_tdata[34:3])),
		.meas        (meas),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_index   (out_index),
		.out_value   (out_value),
		.out_last    (m_tlast)
	);

	assign m_tdata = {5'b0, out_value, out_index};

endmodule
`default_nettype wire

@@ hw/rtl/cvkt_ctrl.sv @@
`default_nettype none
module cvkt_ctrl import cvkt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	input  wire opcode_t opcode,
	input  wire stat_t   stat,
	output cmd_t         cmd
);

	state_t     state_q, state_d;
	coord_t     coord_q, coord_d;
	logic       dsel_q, dsel_d;
	logic [2:0] msel_q, msel_d;
	elem_t      ecnt_q, ecnt_d;

	// State register and step counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			coord_q <= '0;
			dsel_q  <= 1'b0;
			msel_q  <= '0;
			ecnt_q  <= '0;
		end else begin
			state_q <= state_d;
			coord_q <= coord_d;
			dsel_q  <= dsel_d;
			msel_q  <= msel_d;
			ecnt_q  <= ecnt_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		coord_d     = coord_q;
		dsel_d      = dsel_q;
		msel_d      = msel_q;
		ecnt_d      = ecnt_q;
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.uop     = UOP_NONE;
		cmd.sel     = '0;
		cmd.last    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					coord_d     = '0;
					ecnt_d      = '0;
					dsel_d      = 1'b0;
					case (opcode)
						OP_PREDICT: state_d = ST_PRED;
						OP_UPDATE:  state_d = ST_PREP;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_PRED: begin
				cmd.uop = UOP_PRED;
				coord_d = coord_q + coord_t'(1);
				if (coord_q == coord_t'(COORDS - 1))
					state_d = ST_EMIT;
			end
			ST_PREP: begin
				cmd.uop = UOP_PREP;
				dsel_d  = 1'b0;
				state_d = ST_DIVS;
			end
			ST_DIVS: begin
				cmd.uop = UOP_DIV_START;
				cmd.sel = {2'b0, dsel_q};
				state_d = ST_DIVW;
			end
			ST_DIVW: begin
				if (!stat.div_busy) begin
					cmd.uop = UOP_DIV_STORE;
					cmd.sel = {2'b0, dsel_q};
					if (!dsel_q) begin
						dsel_d  = 1'b1;
						state_d = ST_DIVS;
					end else begin
						msel_d  = MUL_KP_Y;
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				cmd.uop = UOP_MUL;
				cmd.sel = msel_q;
				state_d = ST_MULF;
			end
			ST_MULF: begin
				cmd.uop = UOP_MUL_FIN;
				cmd.sel = msel_q;
				if (msel_q == MUL_KV_PV) begin
					state_d = ST_COMMIT;
				end else begin
					msel_d  = msel_q + 3'd1;
					state_d = ST_MUL;
				end
			end
			ST_COMMIT: begin
				cmd.uop = UOP_COMMIT;
				coord_d = coord_q + coord_t'(1);
				state_d = (coord_q == coord_t'(COORDS - 1)) ? ST_EMIT : ST_PREP;
			end
			ST_EMIT: begin
				if (!stat.out_busy) begin
					cmd.uop  = UOP_EMIT;
					cmd.sel  = ecnt_q;
					cmd.last = (ecnt_q == elem_t'(NSTATE - 1));
					ecnt_d   = ecnt_q + elem_t'(1);
					if (cmd.last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/cvkt_dp.sv @@
`default_nettype none
module cvkt_dp import cvkt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	output stat_t                 stat,
	input  wire opcode_t          opcode,
	input  wire elem_t            state_index,
	input  wire data_t            state_value,
	input  wire data_t            meas [COORDS],
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output elem_t                 out_index,
	output data_t                 out_value,
	output logic                  out_last
);

	// Per-coordinate records; the coordinate at work always sits at entry 0,
	// and the records rotate by one after each coordinate is done.
	data_t est_p_q [COORDS];
	data_t est_v_q [COORDS];
	data_t pe_p_q  [COORDS];
	data_t pe_v_q  [COORDS];
	data_t cov_q   [COORDS][4];
	data_t pcov_q  [COORDS][4];
	data_t z_q     [COORDS];

	logic [CFG_W-1:0] q_q, r_q;
	logic             kind_pred_q;

	data_t y_q, s_q, kp_q, kv_q, m_q;
	data_t xp_n_q, xv_n_q;
	data_t n_q [4];

	logic [DIV_W-1:0] dn_q, quo_q;
	umag_t            rem_q, dden_q;
	logic [CNT_W-1:0] dcnt_q;
	logic             dbusy_q, dneg_q, dzero_q;

	logic [2*DATA_W-1:0] prod_s1;
	logic                neg_s1;

	logic  out_valid_q, out_last_q;
	elem_t out_index_q;
	data_t out_value_q;

	// Predict arithmetic for the record at entry 0.
	data_t pr_xp, pr_n0, pr_n1, pr_n2, pr_n3;
	sum_t  qs, rs;

	always_comb begin
		qs    = sum_t'({1'b0, q_q});
		rs    = sum_t'({1'b0, r_q});
		pr_xp = sat_sum(sum_t'(est_p_q[0]) + sum_t'(est_v_q[0]));
		pr_n0 = sat_sum(sum_t'(cov_q[0][0]) + sum_t'(cov_q[0][1]) + sum_t'(cov_q[0][2])
			+ sum_t'(cov_q[0][3]) + qs);
		pr_n1 = sat_sum(sum_t'(cov_q[0][1]) + sum_t'(cov_q[0][3]));
		pr_n2 = sat_sum(sum_t'(cov_q[0][2]) + sum_t'(cov_q[0][3]));
		pr_n3 = sat_sum(sum_t'(cov_q[0][3]) + qs);
	end

	// Multiplier operand select.
	data_t mul_a, mul_b;
	always_comb begin
		case (cmd.sel)
			MUL_KP_Y:  begin mul_a = kp_q; mul_b = y_q;          end
			MUL_KV_Y:  begin mul_a = kv_q; mul_b = y_q;          end
			MUL_M_PP:  begin mul_a = m_q;  mul_b = pcov_q[0][0]; end
			MUL_M_PV:  begin mul_a = m_q;  mul_b = pcov_q[0][1]; end
			MUL_KV_PP: begin mul_a = kv_q; mul_b = pcov_q[0][0]; end
			default:   begin mul_a = kv_q; mul_b = pcov_q[0][1]; end
		endcase
	end

	// Product scaled back to the data format.
	data_t mul_f;
	assign mul_f = from_mag(neg_s1, prod_s1[2*DATA_W-1:FRAC]);

	// Divider result.
	data_t div_f;
	assign div_f = dzero_q ? '0 : from_mag(dneg_q, quo_q);

	// One restoring step of the divider.
	logic [DATA_W:0] rem_sh;
	logic            rem_ge;
	assign rem_sh = {rem_q, dn_q[DIV_W-1]};
	assign rem_ge = rem_sh >= {1'b0, dden_q};

	data_t div_num;
	assign div_num = cmd.sel[0] ? pcov_q[0][2] : pcov_q[0][0];

	// Configuration, divider and output control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q         <= NOISE_RESET;
			r_q         <= NOISE_RESET;
			dbusy_q     <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_Q:   q_q <= cfg_data;
					default: r_q <= cfg_data;
				endcase
			end
			if (cmd.uop == UOP_DIV_START) begin
				dbusy_q <= 1'b1;
				dcnt_q  <= CNT_W'(DIV_W);
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q - CNT_W'(1);
				if (dcnt_q == CNT_W'(1))
					dbusy_q <= 1'b0;
			end
			if (cmd.uop == UOP_EMIT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath registers; the tracker state clears to zero at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_pred_q <= 1'b0;
			for (int c = 0; c < COORDS; c++) begin
				est_p_q[c] <= '0;
				est_v_q[c] <= '0;
				pe_p_q[c]  <= '0;
				pe_v_q[c]  <= '0;
				z_q[c]     <= '0;
				for (int k = 0; k < 4; k++) begin
					cov_q[c][k]  <= '0;
					pcov_q[c][k] <= '0;
				end
			end
			y_q    <= '0;
			s_q    <= '0;
			kp_q   <= '0;
			kv_q   <= '0;
			m_q    <= '0;
			xp_n_q <= '0;
			xv_n_q <= '0;
			for (int k = 0; k < 4; k++)
				n_q[k] <= '0;
			dn_q        <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			dden_q      <= '0;
			dneg_q      <= 1'b0;
			dzero_q     <= 1'b0;
			prod_s1     <= '0;
			neg_s1      <= 1'b0;
			out_index_q <= '0;
			out_last_q  <= 1'b0;
			out_value_q <= '0;
		end else begin
			if (cmd.capture) begin
				kind_pred_q <= (opcode == OP_PREDICT);
				for (int c = 0; c < COORDS; c++)
					z_q[c] <= meas[c];
				if (opcode == OP_INIT) begin
					if (elem_is_vel(state_index))
						est_v_q[elem_coord(state_index)] <= state_value;
					else
						est_p_q[elem_coord(state_index)] <= state_value;
				end
			end

			case (cmd.uop)
				UOP_PRED: begin
					for (int c = 0; c < COORDS - 1; c++) begin
						est_p_q[c] <= est_p_q[c+1];
						est_v_q[c] <= est_v_q[c+1];
						pe_p_q[c]  <= pe_p_q[c+1];
						pe_v_q[c]  <= pe_v_q[c+1];
						z_q[c]     <= z_q[c+1];
						for (int k = 0; k < 4; k++) begin
							cov_q[c][k]  <= cov_q[c+1][k];
							pcov_q[c][k] <= pcov_q[c+1][k];
						end
					end
					est_p_q[COORDS-1] <= est_p_q[0];
					est_v_q[COORDS-1] <= est_v_q[0];
					z_q[COORDS-1]     <= z_q[0];
					for (int k = 0; k < 4; k++)
						cov_q[COORDS-1][k] <= cov_q[0][k];
					pe_p_q[COORDS-1]    <= pr_xp;
					pe_v_q[COORDS-1]    <= est_v_q[0];
					pcov_q[COORDS-1][0] <= pr_n0;
					pcov_q[COORDS-1][1] <= pr_n1;
					pcov_q[COORDS-1][2] <= pr_n2;
					pcov_q[COORDS-1][3] <= pr_n3;
				end
				UOP_PREP: begin
					y_q <= sat_sum(sum_t'(z_q[0]) - sum_t'(pe_p_q[0]));
					s_q <= sat_sum(sum_t'(pcov_q[0][0]) + rs);
				end
				UOP_DIV_START: begin
					dn_q    <= {mag(div_num), FRAC'(0)};
					dden_q  <= mag(s_q);
					dneg_q  <= div_num[DATA_W-1] ^ s_q[DATA_W-1];
					dzero_q <= (s_q == '0);
					rem_q   <= '0;
					quo_q   <= '0;
				end
				UOP_DIV_STORE: begin
					if (cmd.sel[0]) begin
						kv_q <= div_f;
					end else begin
						kp_q <= div_f;
						m_q  <= sat_sum(ONE - sum_t'(div_f));
					end
				end
				UOP_MUL: begin
					prod_s1 <= (2*DATA_W)'(mag(mul_a)) * (2*DATA_W)'(mag(mul_b));
					neg_s1  <= mul_a[DATA_W-1] ^ mul_b[DATA_W-1];
				end
				UOP_MUL_FIN: begin
					case (cmd.sel)
						MUL_KP_Y:  xp_n_q <= sat_sum(sum_t'(pe_p_q[0]) + sum_t'(mul_f));
						MUL_KV_Y:  xv_n_q <= sat_sum(sum_t'(pe_v_q[0]) + sum_t'(mul_f));
						MUL_M_PP:  n_q[0] <= mul_f;
						MUL_M_PV:  n_q[1] <= mul_f;
						MUL_KV_PP: n_q[2] <= sat_sum(sum_t'(pcov_q[0][2]) - sum_t'(mul_f));
						default:   n_q[3] <= sat_sum(sum_t'(pcov_q[0][3]) - sum_t'(mul_f));
					endcase
				end
				UOP_COMMIT: begin
					for (int c = 0; c < COORDS - 1; c++) begin
						est_p_q[c] <= est_p_q[c+1];
						est_v_q[c] <= est_v_q[c+1];
						pe_p_q[c]  <= pe_p_q[c+1];
						pe_v_q[c]  <= pe_v_q[c+1];
						z_q[c]     <= z_q[c+1];
						for (int k = 0; k < 4; k++) begin
							cov_q[c][k]  <= cov_q[c+1][k];
							pcov_q[c][k] <= pcov_q[c+1][k];
						end
					end
					pe_p_q[COORDS-1]  <= pe_p_q[0];
					pe_v_q[COORDS-1]  <= pe_v_q[0];
					z_q[COORDS-1]     <= z_q[0];
					for (int k = 0; k < 4; k++) begin
						pcov_q[COORDS-1][k] <= pcov_q[0][k];
						cov_q[COORDS-1][k]  <= n_q[k];
					end
					est_p_q[COORDS-1] <= xp_n_q;
					est_v_q[COORDS-1] <= xv_n_q;
				end
				UOP_EMIT: begin
					out_index_q <= cmd.sel;
					out_last_q  <= cmd.last;
					if (kind_pred_q)
						out_value_q <= elem_is_vel(cmd.sel) ? pe_v_q[elem_coord(cmd.sel)]
							: pe_p_q[elem_coord(cmd.sel)];
					else
						out_value_q <= elem_is_vel(cmd.sel) ? est_v_q[elem_coord(cmd.sel)]
							: est_p_q[elem_coord(cmd.sel)];
				end
				default: ;
			endcase

			// Divider iteration runs on its own once started.
			if (dbusy_q) begin
				rem_q <= rem_ge ? umag_t'(rem_sh - {1'b0, dden_q}) : rem_sh[DATA_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], rem_ge};
				dn_q  <= {dn_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign stat.div_busy = dbusy_q;
	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_index     = out_index_q;
	assign out_value     = out_value_q;
	assign out_last      = out_last_q;

endmodule
`default_nettype wire
